// ===== rtl/core/tkpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tkpq_pkg;

    // Stream payload widths (whole bytes)
    localparam int unsigned IN_W   = 40;
    localparam int unsigned OUT_W  = 16;

    // APB port widths
    localparam int unsigned CFG_AW = 5;
    localparam int unsigned CFG_DW = 32;

    localparam logic [5:0] NO_KEY  = 6'h3F;
    localparam logic [7:0] SAT_MAX = 8'hFF;

    // Register reset values
    localparam logic [7:0]  RST_STABLE_POLLS  = 8'd3;
    localparam logic [7:0]  RST_RELEASE_POLLS = 8'd3;
    localparam logic [15:0] RST_PRESS_MS      = 16'd60;
    localparam logic [15:0] RST_BOOT_HOLD_MS  = 16'd6000;
    localparam logic [5:0]  RST_BUTTON_COUNT  = 6'd16;

    // Register map, word index = paddr[4:2]
    typedef enum logic [2:0] {
        REG_STABLE_POLLS  = 3'd0,
        REG_RELEASE_POLLS = 3'd1,
        REG_PRESS_MS      = 3'd2,
        REG_BOOT_HOLD_MS  = 3'd3,
        REG_BUTTON_COUNT  = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [7:0]  stable_polls;
        logic [7:0]  release_polls;
        logic [15:0] press_ms;
        logic [15:0] boot_hold_ms;
        logic [5:0]  button_count;
    } t_cfg;

    typedef struct packed {
        logic        touching;
        logic        button_hit;
        logic [4:0]  button;
        logic        host_ready;
        logic [31:0] now_ms;
    } t_item;

    typedef struct packed {
        logic [5:0]  candidate_key;
        logic [7:0]  candidate_polls;
        logic [7:0]  idle_polls;
        logic [5:0]  active_key;
        logic        armed;
        logic        down_queued;
        logic        key_down;
        logic [31:0] key_up_deadline;
        logic [31:0] boot_deadline;
        logic        boot_deadline_set;
    } t_state;

    typedef struct packed {
        logic       press_shown;
        logic       key_down_sent;
        logic       key_up_sent;
        logic       release_shown;
        logic       boot_request;
        logic [4:0] key;
    } t_result;

    localparam t_state STATE_RST = '{
        candidate_key:     NO_KEY,
        candidate_polls:   8'd0,
        idle_polls:        8'd0,
        active_key:        NO_KEY,
        armed:             1'b1,
        down_queued:       1'b0,
        key_down:          1'b0,
        key_up_deadline:   32'd0,
        boot_deadline:     32'd0,
        boot_deadline_set: 1'b0
    };

    // Deadline passed when (now - deadline) is non-negative as a signed value
    function automatic logic reached(input logic [31:0] now, input logic [31:0] deadline);
        logic [31:0] diff;
        diff = now - deadline;
        return ~diff[31];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tkpq_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkpq_cfg (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkpq_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [tkpq_pkg::CFG_DW-1:0]   pwdata,
    output logic      [tkpq_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready,
    output tkpq_pkg::t_cfg                     o_cfg
);
    import tkpq_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[CFG_AW-1:2]);
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.stable_polls  <= RST_STABLE_POLLS;
            r_cfg.release_polls <= RST_RELEASE_POLLS;
            r_cfg.press_ms      <= RST_PRESS_MS;
            r_cfg.boot_hold_ms  <= RST_BOOT_HOLD_MS;
            r_cfg.button_count  <= RST_BUTTON_COUNT;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STABLE_POLLS:  r_cfg.stable_polls  <= pwdata[7:0];
                REG_RELEASE_POLLS: r_cfg.release_polls <= pwdata[7:0];
                REG_PRESS_MS:      r_cfg.press_ms      <= pwdata[15:0];
                REG_BOOT_HOLD_MS:  r_cfg.boot_hold_ms  <= pwdata[15:0];
                REG_BUTTON_COUNT:  r_cfg.button_count  <= pwdata[5:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STABLE_POLLS:  prdata = {24'd0, r_cfg.stable_polls};
            REG_RELEASE_POLLS: prdata = {24'd0, r_cfg.release_polls};
            REG_PRESS_MS:      prdata = {16'd0, r_cfg.press_ms};
            REG_BOOT_HOLD_MS:  prdata = {16'd0, r_cfg.boot_hold_ms};
            REG_BUTTON_COUNT:  prdata = {26'd0, r_cfg.button_count};
            default:           prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// ===== rtl/core/tkpq_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tkpq_step #(
    parameter int unsigned MAX_BUTTONS = 32
) (
    input  wire tkpq_pkg::t_cfg    i_cfg,
    input  wire tkpq_pkg::t_item   i_item,
    input  wire tkpq_pkg::t_state  i_state,
    output tkpq_pkg::t_state       o_state,
    output tkpq_pkg::t_result      o_result
);
    import tkpq_pkg::*;

    localparam logic [5:0] MAX_CNT = 6'(MAX_BUTTONS);

    t_state     n;
    t_result    res;
    logic [5:0] count;
    logic [5:0] released;
    logic       tb_valid;
    logic       boot_key;

    always_comb begin
        n        = i_state;
        res      = '0;
        released = NO_KEY;
        count    = (i_cfg.button_count > MAX_CNT) ? MAX_CNT : i_cfg.button_count;
        tb_valid = i_item.touching & i_item.button_hit & ({1'b0, i_item.button} < count);

        // Debounce: same button on consecutive polls
        if (n.armed && tb_valid) begin
            if ({1'b0, i_item.button} == n.candidate_key) begin
                if (n.candidate_polls != SAT_MAX) begin
                    n.candidate_polls = n.candidate_polls + 8'd1;
                end
            end else begin
                n.candidate_key   = {1'b0, i_item.button};
                n.candidate_polls = 8'd1;
            end
            if (n.candidate_polls >= i_cfg.stable_polls) begin
                n.active_key        = n.candidate_key;
                n.armed             = 1'b0;
                n.down_queued       = 1'b1;
                n.idle_polls        = 8'd0;
                n.boot_deadline_set = ({1'b0, n.active_key} + 7'd1) == {1'b0, count};
                n.boot_deadline     = n.boot_deadline_set ?
                                      i_item.now_ms + {16'd0, i_cfg.boot_hold_ms} : 32'd0;
                res.press_shown     = 1'b1;
            end
        end else if (n.armed) begin
            n.candidate_key   = NO_KEY;
            n.candidate_polls = 8'd0;
        end

        boot_key = ({1'b0, n.active_key} + 7'd1) == {1'b0, count};

        if (!n.armed) begin
            if (boot_key && tb_valid && ({1'b0, i_item.button} == n.active_key) &&
                n.boot_deadline_set && reached(i_item.now_ms, n.boot_deadline)) begin
                res.boot_request = 1'b1;
            end

            if (i_item.touching) begin
                n.idle_polls = 8'd0;
            end else if (n.idle_polls != SAT_MAX) begin
                n.idle_polls = n.idle_polls + 8'd1;
            end

            if (n.down_queued && i_item.host_ready) begin
                n.down_queued     = 1'b0;
                n.key_down        = 1'b1;
                n.key_up_deadline = i_item.now_ms + {16'd0, i_cfg.press_ms};
                res.key_down_sent = 1'b1;
            end
            if (n.key_down && reached(i_item.now_ms, n.key_up_deadline) &&
                i_item.host_ready) begin
                n.key_down      = 1'b0;
                res.key_up_sent = 1'b1;
            end

            // Normal release once all reports are out
            if (!n.key_down && !n.down_queued &&
                n.idle_polls >= i_cfg.release_polls) begin
                released            = n.active_key;
                n.active_key        = NO_KEY;
                n.candidate_key     = NO_KEY;
                n.candidate_polls   = 8'd0;
                n.armed             = 1'b1;
                n.boot_deadline_set = 1'b0;
                res.release_shown   = 1'b1;
            end
            // Press never reported: drop it on release
            if (n.down_queued && n.idle_polls >= i_cfg.release_polls) begin
                n.down_queued       = 1'b0;
                released            = n.active_key;
                n.active_key        = NO_KEY;
                n.armed             = 1'b1;
                n.boot_deadline_set = 1'b0;
                res.release_shown   = 1'b1;
            end
        end

        if (n.active_key != NO_KEY) begin
            res.key = n.active_key[4:0];
        end else if (released != NO_KEY) begin
            res.key = released[4:0];
        end else begin
            res.key = 5'd0;
        end
    end

    assign o_state  = n;
    assign o_result = res;

endmodule

`default_nettype wire

// ===== rtl/core/touch_key_press_qualifier_core.sv =====
`timescale 1ns / 1ps
// A poll passes through the input register and then the result register to the master side.
// Throughput: one poll per cycle while m_axis_tready keeps the result register draining;
// the qualifier state is updated in one pass between the input register and the result register.
// Reset: synchronous, active low; clears state to armed / no key and loads the
// register defaults (3, 3, 60 ms, 6000 ms, 16 buttons).
`default_nettype none

module touch_key_press_qualifier_core #(
    parameter int unsigned MAX_BUTTONS = 32
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // Poll input
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] touching, [1] button_hit, [6:2] button, [7] host_ready, [39:8] now_ms
    input  wire logic [tkpq_pkg::IN_W-1:0]     s_axis_tdata,
    // Result output
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // [0] press_shown, [1] key_down_sent, [2] key_up_sent, [3] release_shown,
    // [4] boot_request, [9:5] key, [15:10] zero
    output logic      [tkpq_pkg::OUT_W-1:0]    m_axis_tdata,
    // Configuration
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tkpq_pkg::CFG_AW-1:0]   paddr,
    input  wire logic [tkpq_pkg::CFG_DW-1:0]   pwdata,
    output logic      [tkpq_pkg::CFG_DW-1:0]   prdata,
    output logic                               pready
);
    import tkpq_pkg::*;

    t_cfg    w_cfg;

    // Input register
    logic    r_in_valid;
    t_item   r_in_item;
    t_item   w_item;

    // Qualifier state
    t_state  r_state;
    t_state  n_state;
    t_result w_result;

    // Result register
    logic    r_out_valid;
    t_result r_out;

    logic    w_advance;

    tkpq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // Unpack the poll, lowest field first
    assign w_item.touching   = s_axis_tdata[0];
    assign w_item.button_hit = s_axis_tdata[1];
    assign w_item.button     = s_axis_tdata[6:2];
    assign w_item.host_ready = s_axis_tdata[7];
    assign w_item.now_ms     = s_axis_tdata[39:8];

    // The held poll moves on whenever the result register is free or drains
    assign w_advance     = r_in_valid & (~r_out_valid | m_axis_tready);
    assign s_axis_tready = ~r_in_valid | w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= w_item;
        end
    end

    tkpq_step #(
        .MAX_BUTTONS (MAX_BUTTONS)
    ) u_step (
        .i_cfg    (w_cfg),
        .i_item   (r_in_item),
        .i_state  (r_state),
        .o_state  (n_state),
        .o_result (w_result)
    );

    // State commits only when the poll's result is captured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RST;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.key, r_out.boot_request, r_out.release_shown,
                            r_out.key_up_sent, r_out.key_down_sent, r_out.press_shown};

    // A disarmed qualifier always owns a key
    a_active_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_state.armed |-> (r_state.active_key != NO_KEY))
        else $error("disarmed without an active key");

    // Pending key-down and an outstanding key-up exclude each other
    a_report_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_state.down_queued && r_state.key_down))
        else $error("press pending while key is down");

    // Re-arming only happens once no report is outstanding
    a_armed_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.armed |-> (!r_state.down_queued && !r_state.key_down))
        else $error("armed with a report outstanding");

    // A held poll and the state stay put while the result side is stalled
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_advance) |=> (r_in_valid && $stable(r_in_item) && $stable(r_state)))
        else $error("stalled poll or state changed");

endmodule

`default_nettype wire
